/* sv/msra_pkg.sv */
// msra_pkg: shared types and constants for the register alu
// no dependencies
package msra_pkg;
   localparam int REG_COUNT = 32;
   localparam int IDX_W = $clog2(REG_COUNT);

   localparam logic [4:0] OP_ADD = 5'd0;
   localparam logic [4:0] OP_SUB = 5'd1;
   localparam logic [4:0] OP_ADDI = 5'd2;
   localparam logic [4:0] OP_ADDU = 5'd3;
   localparam logic [4:0] OP_ADDI_U = 5'd4;
   localparam logic [4:0] OP_SUBU = 5'd5;
   localparam logic [4:0] OP_MUL = 5'd6;
   localparam logic [4:0] OP_AND = 5'd7;
   localparam logic [4:0] OP_OR = 5'd8;
   localparam logic [4:0] OP_XOR = 5'd9;
   localparam logic [4:0] OP_ANDI = 5'd10;
   localparam logic [4:0] OP_ORI = 5'd11;
   localparam logic [4:0] OP_SLL = 5'd12;
   localparam logic [4:0] OP_SRL = 5'd13;
   localparam logic [4:0] OP_MULT = 5'd14;
   localparam logic [4:0] OP_DIV = 5'd15;
   localparam logic [4:0] OP_LI = 5'd16;
   localparam logic [4:0] OP_MOVE = 5'd17;
   localparam logic [4:0] OP_MFHI = 5'd18;
   localparam logic [4:0] OP_MFLO = 5'd19;

   localparam logic [1:0] IT_MUL = 2'd0;
   localparam logic [1:0] IT_DIV = 2'd1;

   typedef struct packed {
      logic       start;
      logic [1:0] kind;
      logic [31:0] a;
      logic [31:0] b;
   } iter_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hi;
      logic [31:0] lo;
   } iter_rsp_type;
endpackage

/* sv/msra_iter.sv */
// msra_iter: shared shift-add / shift-subtract unit for multiply and divide
// depends on msra_pkg
module msra_iter
   import msra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  iter_cmd_type cmd,
   output iter_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] sh_ff, sh_in;
   logic [31:0] opb_ff, opb_in;
   logic        na_ff, na_in, nb_ff, nb_in;
   logic        done_ff, done_in;
   logic [32:0] sum;
   logic [31:0] q, r;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      kind_in = kind_ff;
      acc_in = acc_ff;
      sh_in = sh_ff;
      opb_in = opb_ff;
      na_in = na_ff;
      nb_in = nb_ff;
      done_in = 1'b0;
      sum = 33'd0;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in = 6'd0;
         kind_in = cmd.kind;
         acc_in = 32'd0;
         na_in = cmd.kind == IT_DIV && cmd.a[31];
         nb_in = cmd.kind == IT_DIV && cmd.b[31];
         sh_in = na_in ? 32'd0 - cmd.a : cmd.a;
         opb_in = nb_in ? 32'd0 - cmd.b : cmd.b;
      end else if (busy_ff) begin
         if (kind_ff == IT_MUL) begin
            sum = {1'b0, acc_ff} + (sh_ff[0] ? {1'b0, opb_ff} : 33'd0);
            acc_in = sum[32:1];
            sh_in = {sum[0], sh_ff[31:1]};
         end else begin
            sum = {acc_ff, sh_ff[31]} - {1'b0, opb_ff};
            if (sum[32]) begin
               acc_in = {acc_ff[30:0], sh_ff[31]};
               sh_in = {sh_ff[30:0], 1'b0};
            end else begin
               acc_in = sum[31:0];
               sh_in = {sh_ff[30:0], 1'b1};
            end
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      kind_ff <= kind_in;
      acc_ff <= acc_in;
      sh_ff <= sh_in;
      opb_ff <= opb_in;
      na_ff <= na_in;
      nb_ff <= nb_in;
   end

   assign q = sh_ff;
   assign r = acc_ff;
   always_comb begin
      rsp.done = done_ff;
      if (kind_ff == IT_MUL) begin
         rsp.hi = acc_ff;
         rsp.lo = sh_ff;
      end else begin
         rsp.lo = (na_ff != nb_ff) ? 32'd0 - q : q;
         rsp.hi = na_ff ? 32'd0 - r : r;
      end
   end
endmodule

/* sv/mips_subset_register_alu.sv */
// mips_subset_register_alu: one decoded instruction per transaction on a
// 32 x 32 register file with hi and lo; depends on msra_pkg, msra_iter
//
// req channel carries one instruction per transaction, rsp channel one
// result per instruction. sources are read at the accepting edge; simple
// operations execute in the next cycle and rsp_tvalid rises after that
// edge. mul, mult and div run on the shared shift-add / shift-subtract
// unit, one bit per cycle, and the result is registered once the unit
// reports done, passing through ST_EXEC and ST_WAIT. req_tready is high only
// when no instruction is in flight and the result register is empty, so
// the next accept can come in the cycle after the result is taken. a
// stalled receiver holds rsp_tvalid and the result steady and blocks
// further accepts. reset clears the register file, hi and lo, drops any
// transaction in progress and holds req_tready low. division by zero
// returns status 1 and changes no state.
module mips_subset_register_alu
   import msra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[4:0], dest[9:5], src_a[14:10], src_b[19:15], immediate[51:20], zero pad
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // wrote[0], written_reg[5:1], written_value[37:6], hi_value[69:38],
   // lo_value[101:70], status[102], zero pad
   output logic [103:0] rsp_tdata
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_OUT = 2'd3;

   logic [1:0]  st_ff, st_in;
   logic [31:0] rf_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [31:0] hi_ff, lo_ff;
   logic [4:0]  mode_ff, dest_ff;
   logic [31:0] imm_ff, a_ff, b_ff;
   logic [103:0] out_ff;
   logic [4:0]  r_mode, r_dest, r_sa, r_sb;
   logic [31:0] r_imm;
   logic        acc;
   iter_cmd_type cmd;
   iter_rsp_type irsp;
   logic [31:0] val;
   logic        wr, dz, hilo_wr, is_iter;
   logic [31:0] nhi, nlo;
   logic        fin;

   assign r_mode = req_tdata[4:0];
   assign r_dest = req_tdata[9:5];
   assign r_sa = req_tdata[14:10];
   assign r_sb = req_tdata[19:15];
   assign r_imm = req_tdata[51:20];
   assign req_tready = !reset && st_ff == ST_IDLE;
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = st_ff == ST_OUT;
   assign rsp_tdata = out_ff;

   function automatic logic [31:0] rd(input logic [4:0] i, input logic [REG_COUNT-1:0] v,
                                      input logic [31:0] d);
      logic [31:0] res;
      res = 32'd0;
      if (32'(i) < REG_COUNT && v[IDX_W'(i)]) res = d;
      return res;
   endfunction

   assign is_iter = mode_ff == OP_MUL || mode_ff == OP_MULT || mode_ff == OP_DIV;
   assign dz = mode_ff == OP_DIV && b_ff == 32'd0;
   assign cmd.start = st_ff == ST_EXEC && is_iter && !dz;
   assign cmd.kind = mode_ff == OP_DIV ? IT_DIV : IT_MUL;
   assign cmd.a = a_ff;
   assign cmd.b = b_ff;

   msra_iter u_iter (.clock(clock), .reset(reset), .cmd(cmd), .rsp(irsp));

   always_comb begin
      val = 32'd0;
      wr = 1'b1;
      hilo_wr = 1'b0;
      case (mode_ff)
         OP_ADD, OP_ADDU: val = a_ff + b_ff;
         OP_SUB, OP_SUBU: val = a_ff - b_ff;
         OP_ADDI, OP_ADDI_U: val = a_ff + imm_ff;
         OP_MUL: val = irsp.lo;
         OP_AND: val = a_ff & b_ff;
         OP_OR: val = a_ff | b_ff;
         OP_XOR: val = a_ff ^ b_ff;
         OP_ANDI: val = a_ff & imm_ff;
         OP_ORI: val = a_ff | imm_ff;
         OP_SLL: val = imm_ff >= 32'd32 ? 32'd0 : a_ff << imm_ff[4:0];
         OP_SRL: val = imm_ff >= 32'd32 ? 32'd0 : a_ff >> imm_ff[4:0];
         OP_MULT, OP_DIV: begin
            wr = 1'b0;
            hilo_wr = !dz;
         end
         OP_LI: val = imm_ff;
         OP_MOVE: val = a_ff;
         OP_MFHI: val = hi_ff;
         OP_MFLO: val = lo_ff;
         default: wr = 1'b0;
      endcase
      wr = wr && dest_ff != 5'd0 && 32'(dest_ff) < REG_COUNT;
      if (!wr) val = 32'd0;
      nhi = hilo_wr ? irsp.hi : hi_ff;
      nlo = hilo_wr ? irsp.lo : lo_ff;
   end

   assign fin = (st_ff == ST_EXEC && (!is_iter || dz)) || (st_ff == ST_WAIT && irsp.done);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (acc) st_in = ST_EXEC;
         ST_EXEC: st_in = fin ? ST_OUT : ST_WAIT;
         ST_WAIT: if (irsp.done) st_in = ST_OUT;
         ST_OUT: if (rsp_tready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         vld_ff <= '0;
         hi_ff <= 32'd0;
         lo_ff <= 32'd0;
      end else begin
         st_ff <= st_in;
         if (fin) begin
            if (wr) vld_ff[IDX_W'(dest_ff)] <= 1'b1;
            hi_ff <= nhi;
            lo_ff <= nlo;
         end
      end
      if (fin) begin
         if (wr) rf_ff[IDX_W'(dest_ff)] <= val;
         out_ff <= {1'b0, dz, nlo, nhi, val, wr ? dest_ff : 5'd0, wr};
      end
      if (acc) begin
         mode_ff <= r_mode;
         dest_ff <= r_dest;
         imm_ff <= r_imm;
         a_ff <= rd(r_sa, vld_ff, rf_ff[IDX_W'(r_sa)]);
         b_ff <= rd(r_sb, vld_ff, rf_ff[IDX_W'(r_sb)]);
      end
   end
endmodule
